// ===== sv/vsbv_pkg.sv =====
package vsbv_pkg;

   // parameter defaults
   localparam int SINE_TABLE_BITS_DEFAULT = 8;
   localparam int PHASE_BITS_DEFAULT      = 24;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_BASE_INCREMENT = 3'd0,
      REG_LFO_INCREMENT  = 3'd1,
      REG_VIBRATO_DEPTH  = 3'd2,
      REG_DECAY_FACTOR   = 3'd3,
      REG_OUTPUT_GAIN    = 3'd4
   } reg_index_type;

   localparam logic [23:0] BASE_INCREMENT_RESET = 24'd153791;
   localparam logic [23:0] LFO_INCREMENT_RESET  = 24'd3495;
   localparam logic [19:0] VIBRATO_DEPTH_RESET  = 20'd6991;
   localparam logic [15:0] DECAY_FACTOR_RESET   = 16'd65529;
   localparam logic [15:0] OUTPUT_GAIN_RESET    = 16'd19661;

   typedef struct packed {
      logic [23:0] base_increment;
      logic [23:0] lfo_increment;
      logic [19:0] vibrato_depth;
      logic [15:0] decay_factor;
      logic [15:0] output_gain;
   } cfg_type;

   // sequencer to datapath
   typedef struct packed {
      logic load;      // take the transaction, advance lfo, decay envelope
      logic dev_mul;   // sine magnitude times vibrato depth
      logic gain_mul;  // advance tone phases, envelope times gain
      logic form;      // build the sample into the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // polynomial sine coefficients, Q30
   localparam logic [63:0] C_A1 = 64'd1686629713;
   localparam logic [63:0] C_A3 = 64'd693598254;
   localparam logic [63:0] C_A5 = 64'd85569306;
   localparam logic [63:0] C_A7 = 64'd5026995;

   // quarter-wave entry k of 2^qbits, Q0.15 magnitude; elaboration time only
   function automatic logic [14:0] sine_entry(input int k, input int qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      x  = 64'(k) << (30 - qbits);
      x2 = (x * x) >> 30;
      p  = C_A5 - ((x2 * C_A7) >> 30);
      p  = C_A3 - ((x2 * p) >> 30);
      p  = C_A1 - ((x2 * p) >> 30);
      s  = (x * p) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

// ===== sv/vsbv_csr.sv =====
module vsbv_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [vsbv_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [vsbv_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [vsbv_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output vsbv_pkg::cfg_type                cfg
);

   logic [2:0]        reg_idx;
   logic              wr_en;
   vsbv_pkg::cfg_type cfg_ff;
   vsbv_pkg::cfg_type cfg_in;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            vsbv_pkg::REG_BASE_INCREMENT: cfg_in.base_increment = pwdata[23:0];
            vsbv_pkg::REG_LFO_INCREMENT:  cfg_in.lfo_increment  = pwdata[23:0];
            vsbv_pkg::REG_VIBRATO_DEPTH:  cfg_in.vibrato_depth  = pwdata[19:0];
            vsbv_pkg::REG_DECAY_FACTOR:   cfg_in.decay_factor   = pwdata[15:0];
            vsbv_pkg::REG_OUTPUT_GAIN:    cfg_in.output_gain    = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         vsbv_pkg::REG_BASE_INCREMENT: prdata = 32'(cfg_ff.base_increment);
         vsbv_pkg::REG_LFO_INCREMENT:  prdata = 32'(cfg_ff.lfo_increment);
         vsbv_pkg::REG_VIBRATO_DEPTH:  prdata = 32'(cfg_ff.vibrato_depth);
         vsbv_pkg::REG_DECAY_FACTOR:   prdata = 32'(cfg_ff.decay_factor);
         vsbv_pkg::REG_OUTPUT_GAIN:    prdata = 32'(cfg_ff.output_gain);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_increment <= vsbv_pkg::BASE_INCREMENT_RESET;
         cfg_ff.lfo_increment  <= vsbv_pkg::LFO_INCREMENT_RESET;
         cfg_ff.vibrato_depth  <= vsbv_pkg::VIBRATO_DEPTH_RESET;
         cfg_ff.decay_factor   <= vsbv_pkg::DECAY_FACTOR_RESET;
         cfg_ff.output_gain    <= vsbv_pkg::OUTPUT_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/vsbv_ctrl.sv =====
module vsbv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vsbv_pkg::status_type status,
   output vsbv_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEV,
      ST_GAIN,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.dev_mul  = (state_ff == ST_DEV);
      cmd.gain_mul = (state_ff == ST_GAIN);
      cmd.form     = (state_ff == ST_OUT);
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = req_valid ? ST_DEV : ST_IDLE;
         ST_DEV:  state_in = ST_GAIN;
         ST_GAIN: state_in = ST_OUT;
         ST_OUT:  state_in = status.out_free ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_dev: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.dev_mul)
      else $error("accepted transaction did not start the deviation product");

   a_form_releases: assert property (@(posedge clock) disable iff (reset)
      (cmd.form && status.out_free) |=> !req_stall)
      else $error("sequencer not ready after the sample was stored");
`endif

endmodule

// ===== sv/vsbv_dp.sv =====
module vsbv_dp #(
   parameter int SINE_TABLE_BITS = vsbv_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int PHASE_BITS      = vsbv_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_trigger,
   input  logic                 req_end_of_buffer,
   input  vsbv_pkg::cfg_type    cfg,
   input  vsbv_pkg::cmd_type    cmd,
   output vsbv_pkg::status_type status,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_sample,
   output logic                 rsp_last
);

   localparam int QB   = SINE_TABLE_BITS - 2;
   localparam int QLEN = 1 << QB;
   localparam int TI_W = QB + 1;
   localparam logic [32:0] PMASK = 33'((64'd1 << PHASE_BITS) - 64'd1);
   localparam logic [15:0] POS_LIMIT = 16'd32767;
   localparam logic [15:0] NEG_LIMIT = 16'd32768;

   typedef logic [QLEN:0][14:0] rom_type;

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k <= QLEN; k++) begin
         r[k] = vsbv_pkg::sine_entry(k, QB);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [PHASE_BITS-1:0] lfo_phase_ff, lfo_phase_in;
   logic [PHASE_BITS-1:0] main_phase_ff, main_phase_in;
   logic [PHASE_BITS-1:0] fifth_phase_ff, fifth_phase_in;
   logic [15:0]           env_ff, env_in;
   logic [14:0]           mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [35:0]           prod_ff, prod_in;
   logic                  last_pend_ff, last_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_sample_ff, rsp_sample_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [15:0]                env_start;
   logic [19:0]                mul_a;
   logic [15:0]                mul_b;
   logic [35:0]                mul_p;
   logic [PHASE_BITS-1:0]      lfo_sum;
   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [1:0]                 quad;
   logic [QB-1:0]              pos;
   logic [TI_W-1:0]            ti;
   logic [19:0]                dev;
   logic [24:0]                step_sum;
   logic [32:0]                inc_wide;
   logic [PHASE_BITS-1:0]      inc;
   logic [PHASE_BITS+1:0]      three_inc;
   logic [PHASE_BITS-1:0]      fifth_step;
   logic [15:0]                mix_mag;
   logic [15:0]                sample_mix;
   logic                       out_free;
   logic                       store;

   // one shared multiplier
   always_comb begin
      env_start = req_trigger ? 16'hFFFF : env_ff;
      mul_a     = 20'(env_start);
      mul_b     = cfg.decay_factor;
      if (cmd.dev_mul) begin
         mul_a = cfg.vibrato_depth;
         mul_b = {1'b0, mag_ff};
      end else if (cmd.gain_mul) begin
         mul_a = 20'(env_ff);
         mul_b = cfg.output_gain;
      end
      mul_p = 36'(mul_a) * 36'(mul_b);
   end

   // lfo phase and quarter-wave lookup
   always_comb begin
      lfo_sum = lfo_phase_ff + PHASE_BITS'(cfg.lfo_increment);
      tab_idx = lfo_sum[PHASE_BITS-1 -: SINE_TABLE_BITS];
      quad    = tab_idx[SINE_TABLE_BITS-1 -: 2];
      pos     = tab_idx[QB-1:0];
      ti      = quad[0] ? (TI_W'(QLEN) - {1'b0, pos}) : {1'b0, pos};
   end

   // bent step, clamped at both ends
   always_comb begin
      dev = prod_ff[34:15];
      if (neg_ff) begin
         step_sum = (25'(dev) > 25'(cfg.base_increment)) ? 25'd0
                  : 25'(cfg.base_increment) - 25'(dev);
      end else begin
         step_sum = 25'(cfg.base_increment) + 25'(dev);
      end
      inc_wide   = 33'(step_sum);
      inc        = (inc_wide > PMASK) ? PMASK[PHASE_BITS-1:0]
                                      : inc_wide[PHASE_BITS-1:0];
      three_inc  = {2'b00, inc} + {1'b0, inc, 1'b0};
      fifth_step = three_inc[PHASE_BITS:1];
   end

   // square mix
   always_comb begin
      mix_mag = prod_ff[31:16];
      if (main_phase_ff[PHASE_BITS-1] && fifth_phase_ff[PHASE_BITS-1]) begin
         sample_mix = (mix_mag > POS_LIMIT) ? POS_LIMIT : mix_mag;
      end else if (!main_phase_ff[PHASE_BITS-1] && !fifth_phase_ff[PHASE_BITS-1]) begin
         sample_mix = 16'd0 - ((mix_mag > NEG_LIMIT) ? NEG_LIMIT : mix_mag);
      end else begin
         sample_mix = 16'd0;
      end
   end

   always_comb begin
      out_free        = !rsp_valid_ff || !rsp_stall;
      status.out_free = out_free;
      store           = cmd.form && out_free;

      lfo_phase_in   = cmd.load ? lfo_sum : lfo_phase_ff;
      env_in         = cmd.load ? mul_p[31:16] : env_ff;
      mag_in         = cmd.load ? SINE_ROM[ti] : mag_ff;
      neg_in         = cmd.load ? quad[1] : neg_ff;
      last_pend_in   = cmd.load ? req_end_of_buffer : last_pend_ff;
      prod_in        = (cmd.dev_mul || cmd.gain_mul) ? mul_p : prod_ff;
      main_phase_in  = cmd.gain_mul ? main_phase_ff + inc : main_phase_ff;
      fifth_phase_in = cmd.gain_mul ? fifth_phase_ff + fifth_step : fifth_phase_ff;

      if (store) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_sample_in = store ? sample_mix : rsp_sample_ff;
      rsp_last_in   = store ? last_pend_ff : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_phase_ff   <= '0;
         main_phase_ff  <= '0;
         fifth_phase_ff <= '0;
         env_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         lfo_phase_ff   <= lfo_phase_in;
         main_phase_ff  <= main_phase_in;
         fifth_phase_ff <= fifth_phase_in;
         env_ff         <= env_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      last_pend_ff  <= last_pend_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_valid_from_form: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(cmd.form))
      else $error("output register loaded without a form command");

   a_phase_moves_on_gain: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(main_phase_ff)) |-> $past(cmd.gain_mul))
      else $error("tone phase moved outside its update step");
`endif

endmodule

// ===== sv/vibrato_square_beep_voice.sv =====
// an accepted request transaction steps through the deviation product, the
// phase update and gain product, and the store state, which raises rsp_valid
// (later while rsp_stall holds it); no new transaction is taken until then, as
// the single shared multiplier forms env*decay, sine*depth and env*gain in turn
// reset: synchronous, active high; clears the three phases, the envelope and
// the sequencer, and loads every configuration register with its default
module vibrato_square_beep_voice #(
   parameter int SINE_TABLE_BITS = vsbv_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int PHASE_BITS      = vsbv_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_trigger,
   input  logic                             req_end_of_buffer,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [15:0]               rsp_sample,
   output logic                             rsp_last,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [vsbv_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [vsbv_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [vsbv_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   vsbv_pkg::cfg_type    cfg;
   vsbv_pkg::cmd_type    cmd;
   vsbv_pkg::status_type status;

   // register bank: writes land on the access phase, reads are combinational
   vsbv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: idle -> deviation product -> phase update and gain product
   // -> store sample, waiting there only while the output register is full
   vsbv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: phase accumulators, quarter-wave rom, shared multiplier and
   // the output register, which lets the next transaction in while a sample
   // still waits to be taken
   vsbv_dp #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_trigger       (req_trigger),
      .req_end_of_buffer (req_end_of_buffer),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_sample        (rsp_sample),
      .rsp_last          (rsp_last)
   );

endmodule
